// ----- design/vdi_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vdi_pkg
// Shared types and constants of the vertex deduplication indexer.
// ----------------------------------------------------------------------------
package vdi_pkg;

    localparam int COORD_W = 32;
    localparam int INDEX_W = 32;

    typedef struct packed {
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [COORD_W-1:0] pos_z;
    } vdi_in_t;

    typedef struct packed {
        logic [INDEX_W-1:0] vertex_index;
        logic               is_new;
        logic               table_full;
    } vdi_out_t;

    // Lookup transaction as it travels down the cell chain.
    typedef struct packed {
        logic    valid;
        logic    hit;
        logic    is_new;
        vdi_in_t vtx;
    } vdi_probe_t;

endpackage
`default_nettype wire

// ----- design/vdi_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vdi_cell
// One table entry: compares a passing probe with its stored vertex, takes the
// vertex if it is the first free entry, and hands the probe to the next cell.
// ----------------------------------------------------------------------------
module vdi_cell
    import vdi_pkg::*;
#(
    parameter int CELL_INDEX = 0,
    parameter int IDX_W      = 10
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             advance,
    input  wire vdi_probe_t       probe_in,
    input  wire logic [IDX_W-1:0] slot_in,
    output vdi_probe_t            probe_out,
    output logic      [IDX_W-1:0] slot_out
);

    vdi_in_t              vtx_reg;
    vdi_in_t              vtx_next;
    logic                 occupied_reg;
    logic                 occupied_next;
    logic                 valid_reg;
    logic                 hit_reg;
    logic                 is_new_reg;
    vdi_in_t              probe_vtx_reg;
    vdi_probe_t           probe_next;
    logic     [IDX_W-1:0] slot_reg;
    logic     [IDX_W-1:0] slot_next;
    logic                 searching;
    logic                 match;

    assign searching = probe_in.valid && !probe_in.hit && !probe_in.is_new;
    assign match     = occupied_reg && (probe_in.vtx == vtx_reg);

    always_comb
    begin
        vtx_next      = vtx_reg;
        occupied_next = occupied_reg;
        probe_next    = probe_out;
        slot_next     = slot_reg;
        if (advance)
        begin
            probe_next = probe_in;
            slot_next  = slot_in;
            if (searching)
            begin
                if (match)
                begin
                    probe_next.hit = 1'b1;
                    slot_next      = IDX_W'(CELL_INDEX);
                end
                else if (!occupied_reg)
                begin
                    // first free entry: insert here
                    probe_next.is_new = 1'b1;
                    slot_next         = IDX_W'(CELL_INDEX);
                    occupied_next     = 1'b1;
                    vtx_next          = probe_in.vtx;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occupied_reg <= 1'b0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            occupied_reg <= occupied_next;
            valid_reg    <= probe_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        vtx_reg       <= vtx_next;
        hit_reg       <= probe_next.hit;
        is_new_reg    <= probe_next.is_new;
        probe_vtx_reg <= probe_next.vtx;
        slot_reg      <= slot_next;
    end

    assign probe_out = '{valid: valid_reg, hit: hit_reg, is_new: is_new_reg,
                         vtx: probe_vtx_reg};
    assign slot_out  = slot_reg;

endmodule
`default_nettype wire

// ----- design/vdi_out_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vdi_out_stage
// Result register at the end of the chain: applies the index offset, flags a
// full table, and produces the chain advance enable.
// ----------------------------------------------------------------------------
module vdi_out_stage
    import vdi_pkg::*;
#(
    parameter int IDX_W = 10
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire vdi_probe_t         probe_in,
    input  wire logic [IDX_W-1:0]   slot_in,
    input  wire logic [INDEX_W-1:0] index_offset,
    output logic                    advance,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output vdi_out_t                out_data
);

    logic     out_valid_reg;
    logic     out_valid_next;
    vdi_out_t out_data_reg;
    vdi_out_t out_data_next;
    logic     placed;

    assign advance = !out_valid_reg || out_ready;
    assign placed  = probe_in.hit || probe_in.is_new;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (advance)
        begin
            out_valid_next             = probe_in.valid;
            out_data_next.vertex_index = placed ? (INDEX_W'(slot_in) + index_offset)
                                                : '0;
            out_data_next.is_new       = probe_in.is_new;
            out_data_next.table_full   = !placed;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
`default_nettype wire

// ----- design/vertex_dedup_indexer_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vertex_dedup_indexer_core
// Vertex deduplication indexer: a chain of TABLE_DEPTH entry cells that each
// probe passes through, hitting a stored vertex or claiming the first free
// entry, followed by a result register.
//
//   channel | signals                       | payload
//   --------+-------------------------------+-----------------------------
//   in      | in_valid / in_ready           | in_data  (pos_x, pos_y, pos_z)
//   out     | out_valid / out_ready         | out_data (vertex_index, is_new,
//           |                               |           table_full)
//   cfg     | cfg_valid / cfg_ready         | cfg_data (index_offset)
//
// From the accepting edge the transaction is registered in the first cell,
// then in each remaining cell in turn, and then in the result register that
// drives out_valid. One transaction enters per cycle while the chain is not
// held. Reset empties every entry and clears index_offset; it takes effect
// at once. While a result waits in the output register the whole chain
// holds, and in_ready is low.
// ----------------------------------------------------------------------------
module vertex_dedup_indexer_core
    import vdi_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire vdi_in_t            in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output vdi_out_t                out_data,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [INDEX_W-1:0] cfg_data
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);

    logic [INDEX_W-1:0] index_offset_reg;
    logic [INDEX_W-1:0] index_offset_next;
    logic               advance;

    vdi_probe_t         probe_chain [TABLE_DEPTH+1];
    logic [IDX_W-1:0]   slot_chain  [TABLE_DEPTH+1];

    assign cfg_ready = 1'b1;

    always_comb
    begin
        index_offset_next = index_offset_reg;
        if (cfg_valid)
        begin
            index_offset_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_offset_reg <= '0;
        end
        else
        begin
            index_offset_reg <= index_offset_next;
        end
    end

    assign in_ready = advance;

    assign probe_chain[0] = '{valid: in_valid, hit: 1'b0, is_new: 1'b0, vtx: in_data};
    assign slot_chain[0]  = '0;

    for (genvar g = 0; g < TABLE_DEPTH; g++)
    begin : g_cell
        vdi_cell #(
            .CELL_INDEX (g),
            .IDX_W      (IDX_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .probe_in  (probe_chain[g]),
            .slot_in   (slot_chain[g]),
            .probe_out (probe_chain[g+1]),
            .slot_out  (slot_chain[g+1])
        );
    end

    vdi_out_stage #(
        .IDX_W (IDX_W)
    ) u_out_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .probe_in     (probe_chain[TABLE_DEPTH]),
        .slot_in      (slot_chain[TABLE_DEPTH]),
        .index_offset (index_offset_reg),
        .advance      (advance),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data)
    );

endmodule
`default_nettype wire

// ----- design/vdi_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vdi_checker
// Port-level checks for the vertex deduplication indexer, bound to the core.
// ----------------------------------------------------------------------------
module vdi_checker
    import vdi_pkg::*;
(
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     in_ready,
    input wire logic     out_valid,
    input wire logic     out_ready,
    input wire vdi_out_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.is_new && out_data.table_full))
        else $error("is_new and table_full both set");

    a_full_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.table_full |-> out_data.vertex_index == '0)
        else $error("nonzero index on full-table miss");

    a_ready_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input ready does not track result drain");

endmodule

bind vertex_dedup_indexer_core vdi_checker u_vdi_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
`default_nettype wire
